FILE: hw/rtl/rgb_conv3x3_filter_core_macros.svh
// Assertion macros shared by the RGB 3x3 convolution filter RTL.
`ifndef RGB_CONV3X3_FILTER_CORE_MACROS_SVH
`define RGB_CONV3X3_FILTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RGBC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgbc assertion failed");
`define RGBC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgbc assertion failed");
`else
`define RGBC_ASSERT_IMP(label, clk, rst, ante, cons)
`define RGBC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/rgbc_pkg.sv
// Types and constants shared by the RGB 3x3 convolution filter modules.
`timescale 1ns / 1ps
`default_nettype none

package rgbc_pkg;

   typedef enum logic [1:0] {
      CSR_MODE   = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_GAUSS16  = 3'd0,
      MODE_DIAG3    = 3'd1,
      MODE_EDGE     = 3'd2,
      MODE_SHARPEN  = 3'd3,
      MODE_EMBOSS   = 3'd4,
      MODE_BOX9     = 3'd5,
      MODE_SMOOTH27 = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      DIV_ONE          = 3'd0,
      DIV_SIXTEEN      = 3'd1,
      DIV_THREE        = 3'd2,
      DIV_NINE         = 3'd3,
      DIV_TWENTYSEVEN  = 3'd4
   } div_type;

   localparam int SUM_W = 14;
   localparam int MUL_W = 13;
   localparam int PROD_W = 26;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [7:0] tap_type;
   typedef tap_type [2:0][2:0] taps_type;
   typedef logic [23:0] pixel_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } lb_ctrl_type;

   // Reciprocal multipliers: floor(s * MUL / 2^SHIFT) equals s / d over the kernel sum range.
   localparam logic [MUL_W-1:0] DIV3_MUL = 13'd683;
   localparam int DIV3_SHIFT = 11;
   localparam logic [MUL_W-1:0] DIV9_MUL = 13'd1821;
   localparam int DIV9_SHIFT = 14;
   localparam logic [MUL_W-1:0] DIV27_MUL = 13'd4855;
   localparam int DIV27_SHIFT = 17;

   localparam logic [2:0]  MODE_RESET   = 3'd0;
   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [15:0] HEIGHT_RESET = 16'd480;
   localparam logic [11:0] MIN_WIDTH    = 12'd3;
   localparam logic [15:0] MIN_HEIGHT   = 16'd3;

endpackage

`default_nettype wire

FILE: hw/rtl/rgbc_line_buf.sv
// Two row memories holding the previous two image rows, with same-address forwarding.
`timescale 1ns / 1ps
`default_nettype none

module rgbc_line_buf
   import rgbc_pkg::*;
#(
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic        clock,
   input  lb_ctrl_type ctrl,
   input  logic [AW-1:0] rd_addr,
   input  logic [AW-1:0] wr_addr,
   input  pixel_type   wr_pix,
   output pixel_type   up_pix,
   output pixel_type   mid_pix
);

   pixel_type upper_mem [DEPTH];
   pixel_type middle_mem [DEPTH];

   pixel_type rd_up_ff;
   pixel_type rd_mid_ff;
   pixel_type fwd_up_ff;
   pixel_type fwd_mid_ff;
   logic      byp_ff;

   assign up_pix  = byp_ff ? fwd_up_ff : rd_up_ff;
   assign mid_pix = byp_ff ? fwd_mid_ff : rd_mid_ff;

   // The middle row value moves up as the new pixel takes its place.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         upper_mem[wr_addr]  <= mid_pix;
         middle_mem[wr_addr] <= wr_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_up_ff   <= upper_mem[rd_addr];
         rd_mid_ff  <= middle_mem[rd_addr];
         byp_ff     <= ctrl.wr_en && (wr_addr == rd_addr);
         fwd_up_ff  <= mid_pix;
         fwd_mid_ff <= wr_pix;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rgbc_kernel.sv
// Kernel sum of one color channel over the 3x3 window, with the matching divisor code.
`timescale 1ns / 1ps
`default_nettype none

module rgbc_kernel
   import rgbc_pkg::*;
(
   input  taps_type   taps,
   input  logic [2:0] mode,
   input  logic       border,
   output sum_type    sum,
   output div_type    div
);

   sum_type v [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            v[r][c] = $signed({6'b0, taps[r][c]});
         end
      end
   end

   always_comb begin
      sum = v[1][1];
      div = DIV_ONE;
      if (!border) begin
         unique case (mode)
            MODE_GAUSS16: begin
               sum = v[0][0] + (v[0][1] <<< 1) + v[0][2]
                   + (v[1][0] <<< 1) + (v[1][1] <<< 2) + (v[1][2] <<< 1)
                   + v[2][0] + (v[2][1] <<< 1) + v[2][2];
               div = DIV_SIXTEEN;
            end
            MODE_DIAG3: begin
               sum = v[0][0] + v[1][1] + v[2][2];
               div = DIV_THREE;
            end
            MODE_EDGE: begin
               sum = (v[1][1] <<< 1) - v[2][1];
            end
            MODE_EMBOSS: begin
               sum = (v[1][1] <<< 1) - v[0][1] - v[2][1];
            end
            MODE_BOX9: begin
               sum = v[0][0] + v[0][1] + v[0][2]
                   + v[1][0] + v[1][1] + v[1][2]
                   + v[2][0] + v[2][1] + v[2][2];
               div = DIV_NINE;
            end
            MODE_SMOOTH27: begin
               sum = v[0][0] + (v[0][1] <<< 2) + v[0][2]
                   + (v[1][0] <<< 2) + ((v[1][1] <<< 3) - v[1][1]) + (v[1][2] <<< 2)
                   + v[2][0] + (v[2][1] <<< 2) + v[2][2];
               div = DIV_TWENTYSEVEN;
            end
            // Sharpen as coded and the unused code both reduce to the center pixel.
            default: begin
               sum = v[1][1];
               div = DIV_ONE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rgbc_scale.sv
// Divides one channel's kernel sum by its constant divisor and keeps the low eight bits.
`timescale 1ns / 1ps
`default_nettype none

module rgbc_scale
   import rgbc_pkg::*;
(
   input  sum_type    sum,
   input  div_type    div,
   output logic [7:0] quot
);

   logic [MUL_W-1:0]  mag;
   logic [MUL_W-1:0]  factor;
   logic [PROD_W-1:0] prod;

   // Sums that need a real divide are never negative.
   assign mag  = sum[MUL_W-1:0];
   assign prod = PROD_W'(mag) * PROD_W'(factor);

   always_comb begin
      case (div)
         DIV_THREE:       factor = DIV3_MUL;
         DIV_NINE:        factor = DIV9_MUL;
         DIV_TWENTYSEVEN: factor = DIV27_MUL;
         default:         factor = '0;
      endcase
   end

   always_comb begin
      case (div)
         DIV_SIXTEEN:     quot = sum[11:4];
         DIV_THREE:       quot = prod[DIV3_SHIFT +: 8];
         DIV_NINE:        quot = prod[DIV9_SHIFT +: 8];
         DIV_TWENTYSEVEN: quot = prod[DIV27_SHIFT +: 8];
         default:         quot = sum[7:0];
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_conv3x3_filter_core.sv
// Top level of the streaming RGB 3x3 convolution filter.
//
// Pixels enter in raster order on the req_ channel, one transfer per pixel; each
// transfer may return zero or one result on the rsp_ channel, both valid/ready.
// The result for the pixel at raster position p is released by input transfer
// p + width + 1, so after the last pixel of a frame width + 1 padding transfers
// (req_is_padding high) drain it; rsp_frame_last marks its final pixel.
// One pixel is accepted every cycle while the output is not stalled: the row
// memories take one read and one write per cycle, and four register stages
// (memory read, window, kernel sum, divide) carry the item.
// A stalled receiver holds the output register; upstream stages keep accepting
// until all four are full, then req_ready drops.
// Reset empties the pipeline, clears the row and column counters and window, and
// loads mode 0, width 640 and height 480; the row memories are not cleared.
// Configuration is to be written by the user through csr_wr_en, csr_index and
// csr_wdata while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_conv3x3_filter_core_macros.svh"

module rgb_conv3x3_filter_core
   import rgbc_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   input  logic        req_is_padding,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_frame_last,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int PW = WW + 16;
   localparam int RST_W = (int'(WIDTH_RESET) > MAX_WIDTH) ? MAX_WIDTH : int'(WIDTH_RESET);
   localparam int RST_LAST = RST_W * int'(HEIGHT_RESET) - 1;
   localparam int RST_BORDER = RST_W * (int'(HEIGHT_RESET) - 1);
   localparam logic [1:0] ROW_FULL = 2'd2;

   typedef struct packed {
      logic produce;
      logic border;
      logic last;
   } item_flags_type;

   typedef pixel_type [2:0][2:0] window_type;

   function automatic logic [WW-1:0] clamp_width(input logic [11:0] v);
      if (v < MIN_WIDTH) begin
         return WW'(MIN_WIDTH);
      end else if (32'(v) > MAX_WIDTH) begin
         return WW'(MAX_WIDTH);
      end
      return WW'(v);
   endfunction

   function automatic logic [15:0] clamp_height(input logic [15:0] v);
      return (v < MIN_HEIGHT) ? MIN_HEIGHT : v;
   endfunction

   // Configuration and frame limits.
   logic [2:0]    mode_ff;
   logic [11:0]   width_ff;
   logic [15:0]   height_ff;
   logic [PW-1:0] lim_last_ff;
   logic [PW-1:0] lim_last_in;
   logic [PW-1:0] lim_border_ff;
   logic [PW-1:0] lim_border_in;
   logic [WW-1:0] w_eff;
   logic [15:0]   h_eff;
   logic [WW-1:0] w_sel;
   logic [15:0]   h_sel;

   // Raster counters.
   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [1:0]    row_ff;
   logic [1:0]    row_in;
   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;
   logic [WW-1:0] col_inc;
   logic          col_wrap;
   item_flags_type acc_flags;
   pixel_type     acc_pix;
   logic          req_fire;

   // Pipeline stages.
   logic           s1_valid_ff;
   logic           s1_valid_in;
   logic [CW-1:0]  s1_addr_ff;
   pixel_type      s1_pix_ff;
   item_flags_type s1_flags_ff;
   logic           s2_valid_ff;
   logic           s2_valid_in;
   logic           s2_border_ff;
   logic           s2_last_ff;
   window_type     window_ff;
   logic           s3_valid_ff;
   logic           s3_valid_in;
   sum_type        s3_sum_ff [3];
   div_type        s3_div_ff [3];
   logic           s3_last_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic [7:0]     rsp_chan_ff [3];
   logic           rsp_last_ff;

   logic rsp_free;
   logic s3_go;
   logic s3_free;
   logic s2_go;
   logic s2_free;
   logic s1_go;

   lb_ctrl_type lb_ctrl;
   pixel_type   lb_up;
   pixel_type   lb_mid;

   taps_type   taps [3];
   sum_type    kern_sum [3];
   div_type    kern_div [3];
   logic [7:0] scaled [3];

   assign w_eff = clamp_width(width_ff);
   assign h_eff = clamp_height(height_ff);

   always_comb begin
      w_sel = w_eff;
      h_sel = h_eff;
      if (csr_wr_en && csr_index == CSR_WIDTH) begin
         w_sel = clamp_width(csr_wdata[11:0]);
      end
      if (csr_wr_en && csr_index == CSR_HEIGHT) begin
         h_sel = clamp_height(csr_wdata);
      end
   end

   assign lim_last_in   = PW'(w_sel) * PW'(h_sel) - PW'(1);
   assign lim_border_in = PW'(w_sel) * PW'(h_sel - 16'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RESET;
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         lim_last_ff   <= PW'(RST_LAST);
         lim_border_ff <= PW'(RST_BORDER);
      end else begin
         lim_last_ff   <= lim_last_in;
         lim_border_ff <= lim_border_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MODE:   mode_ff   <= csr_wdata[2:0];
               CSR_WIDTH:  width_ff  <= csr_wdata[11:0];
               CSR_HEIGHT: height_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Flow control: each stage moves when the one after it is empty or moving.
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign s3_go    = s3_valid_ff && rsp_free;
   assign s3_free  = !s3_valid_ff || rsp_free;
   assign s2_go    = s2_valid_ff && s3_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_go    = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_go);
   assign s2_valid_in  = (s1_go && s1_flags_ff.produce) || (s2_valid_ff && !s2_go);
   assign s3_valid_in  = s2_go || (s3_valid_ff && !s3_go);
   assign rsp_valid_in = s3_go || (rsp_valid_ff && !rsp_ready);

   // Accept stage: position of this item and the result it releases.
   assign acc_pix  = req_is_padding ? '0 : {req_in_red, req_in_green, req_in_blue};
   assign col_inc  = WW'(col_ff) + WW'(1);
   assign col_wrap = col_inc >= w_eff;

   always_comb begin
      acc_flags.produce = (row_ff == ROW_FULL) || (row_ff == 2'd1 && col_ff != '0);
      acc_flags.border  = (col_ff <= CW'(1)) || (pos_ff < PW'(w_eff))
                       || (pos_ff >= lim_border_ff);
      acc_flags.last    = acc_flags.produce && (pos_ff >= lim_last_ff);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      pos_in = pos_ff;
      if (req_fire) begin
         if (acc_flags.last) begin
            col_in = '0;
            row_in = '0;
            pos_in = '0;
         end else begin
            col_in = col_wrap ? '0 : CW'(col_inc);
            if (col_wrap && row_ff != ROW_FULL) begin
               row_in = row_ff + 2'd1;
            end
            if (acc_flags.produce) begin
               pos_in = pos_ff + PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage one: row memory read in flight.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_addr_ff  <= col_ff;
         s1_pix_ff   <= acc_pix;
         s1_flags_ff <= acc_flags;
      end
   end

   assign lb_ctrl.rd_en = req_fire;
   assign lb_ctrl.wr_en = s1_go;

   rgbc_line_buf #(
      .DEPTH(MAX_WIDTH)
   ) u_line_buf (
      .clock  (clock),
      .ctrl   (lb_ctrl),
      .rd_addr(col_ff),
      .wr_addr(s1_addr_ff),
      .wr_pix (s1_pix_ff),
      .up_pix (lb_up),
      .mid_pix(lb_mid)
   );

   // Stage two: the window shifts once for every item.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_go) begin
         for (int r = 0; r < 3; r++) begin
            window_ff[r][0] <= window_ff[r][1];
            window_ff[r][1] <= window_ff[r][2];
         end
         window_ff[0][2] <= lb_up;
         window_ff[1][2] <= lb_mid;
         window_ff[2][2] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_border_ff <= s1_flags_ff.border;
         s2_last_ff   <= s1_flags_ff.last;
      end
   end

   // Channel 2 is red, 1 green, 0 blue.
   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      always_comb begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               taps[ch][r][c] = window_ff[r][c][8*ch +: 8];
            end
         end
      end

      rgbc_kernel u_kernel (
         .taps  (taps[ch]),
         .mode  (mode_ff),
         .border(s2_border_ff),
         .sum   (kern_sum[ch]),
         .div   (kern_div[ch])
      );

      rgbc_scale u_scale (
         .sum (s3_sum_ff[ch]),
         .div (s3_div_ff[ch]),
         .quot(scaled[ch])
      );

      always_ff @(posedge clock) begin
         if (s2_go) begin
            s3_sum_ff[ch] <= kern_sum[ch];
            s3_div_ff[ch] <= kern_div[ch];
         end
         if (s3_go) begin
            rsp_chan_ff[ch] <= scaled[ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         s3_last_ff <= s2_last_ff;
      end
      if (s3_go) begin
         rsp_last_ff <= s3_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_chan_ff[2];
   assign rsp_out_green  = rsp_chan_ff[1];
   assign rsp_out_blue   = rsp_chan_ff[0];
   assign rsp_frame_last = rsp_last_ff;

   `RGBC_ASSERT_NXT(a_frame_end_clears, clock, reset, req_fire && acc_flags.last, col_ff == '0 && row_ff == '0 && pos_ff == '0)
   `RGBC_ASSERT_IMP(a_rsp_from_stage3, clock, reset, $rose(rsp_valid_ff), $past(s3_valid_ff))

endmodule

`default_nettype wire
